// File: rtl/core/page_replacement_fifo_lru_core_defines.svh
// ----------------------------------------------------------------------------
// Page replacement assertion macros
// Each macro expects signals named clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_FIFO_LRU_CORE_DEFINES_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PRF_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("page replacement check failed");
`define PRF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page replacement check failed");
`else
`define PRF_ASSERT(label, cond)
`define PRF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/prf_pkg.sv
// ----------------------------------------------------------------------------
// Page replacement package
// Sizes, register and command codes, and the structs shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prf_pkg;

	localparam int MAX_FRAMES        = 8;
	localparam int PAGE_BITS         = 16;
	localparam int FRAME_IDX_W       = $clog2(MAX_FRAMES);
	localparam int RANK_W            = $clog2(MAX_FRAMES);
	localparam int RANK_MAX          = MAX_FRAMES - 1;
	localparam int COUNT_W           = 4;
	localparam int FAULT_W           = 16;
	localparam int CFG_IDX_W         = 1;
	localparam int FRAME_COUNT_RESET = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_COUNT = 1'b0,
		REG_POLICY_MODE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		POLICY_FIFO = 1'b0,
		POLICY_LRU  = 1'b1
	} policy_t;

	typedef enum logic {
		CMD_REF   = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		policy_t            policy_mode;
	} cfg_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [PAGE_BITS-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic                   hit;
		logic [FRAME_IDX_W-1:0] frame_index;
		logic                   evicted_valid;
		logic [PAGE_BITS-1:0]   evicted_page;
		logic [FAULT_W-1:0]     fault_count;
	} rsp_t;

endpackage

// File: rtl/core/prf_req_if.sv
// ----------------------------------------------------------------------------
// Page replacement request channel
// Carries one command and page number per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prf_req_if;
	import prf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [PAGE_BITS-1:0] page_number;

	modport source (output valid, output cmd, output page_number, input ready);
	modport sink (input valid, input cmd, input page_number, output ready);
endinterface

// File: rtl/core/prf_rsp_if.sv
// ----------------------------------------------------------------------------
// Page replacement response channel
// Carries hit, frame, eviction and fault count for each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prf_rsp_if;
	import prf_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [FRAME_IDX_W-1:0] frame_index;
	logic                   evicted_valid;
	logic [PAGE_BITS-1:0]   evicted_page;
	logic [FAULT_W-1:0]     fault_count;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_count, input ready);
	modport sink (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_count, output ready);
endinterface

// File: rtl/core/prf_cfg_if.sv
// ----------------------------------------------------------------------------
// Page replacement configuration channel
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prf_cfg_if;
	import prf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COUNT_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/prf_cfg_regs.sv
// ----------------------------------------------------------------------------
// Page replacement configuration registers
// Holds frame count and replacement policy, written through the config channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prf_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	prf_cfg_if.sink       cfg,
	output prf_pkg::cfg_t cfg_q
);
	import prf_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count <= COUNT_W'(FRAME_COUNT_RESET);
			cfg_q.policy_mode <= POLICY_FIFO;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_FRAME_COUNT: cfg_q.frame_count <= cfg.data;
				REG_POLICY_MODE: cfg_q.policy_mode <= policy_t'(cfg.data[0]);
				default: ;
			endcase
		end
	end
endmodule

// File: rtl/core/prf_frame_table.sv
// ----------------------------------------------------------------------------
// Page frame table
// Frame state, parallel page lookup, victim choice and age update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_replacement_fifo_lru_core_defines.svh"

module prf_frame_table (
	input  logic          clk,
	input  logic          arst_n,
	input  prf_pkg::cfg_t cfg,
	input  prf_pkg::req_t req_s1,
	input  logic          commit,
	output prf_pkg::rsp_t rsp
);
	import prf_pkg::*;

	logic [MAX_FRAMES-1:0]  valid_q;
	logic [PAGE_BITS-1:0]   page_q [MAX_FRAMES];
	logic [RANK_W-1:0]      rank_q [MAX_FRAMES];
	logic [FAULT_W-1:0]     faults_q;

	logic [COUNT_W-1:0]     n_used;
	logic [MAX_FRAMES-1:0]  in_use;
	logic [MAX_FRAMES-1:0]  match;
	logic [MAX_FRAMES-1:0]  empty;
	logic                   found;
	logic                   has_empty;
	logic [FRAME_IDX_W-1:0] hit_idx;
	logic [FRAME_IDX_W-1:0] empty_idx;
	logic [FRAME_IDX_W-1:0] victim;
	logic [RANK_W-1:0]      best;
	logic [FRAME_IDX_W-1:0] f_sel;
	logic                   f_was_valid;
	logic                   do_age;
	logic                   clear;
	logic [RANK_W-1:0]      old_rank;
	logic [RANK_W-1:0]      rank_aged [MAX_FRAMES];
	logic [FAULT_W-1:0]     faults_next;

	assign clear = (req_s1.cmd == CMD_CLEAR);

	always_comb begin
		n_used = cfg.frame_count;
		if (n_used == '0) begin
			n_used = COUNT_W'(1);
		end else if (n_used > COUNT_W'(MAX_FRAMES)) begin
			n_used = COUNT_W'(MAX_FRAMES);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			in_use[i] = COUNT_W'(i) < n_used;
			match[i]  = in_use[i] && valid_q[i] && (page_q[i] == req_s1.page_number);
			empty[i]  = in_use[i] && !valid_q[i];
		end
	end

	// Lowest-numbered match and lowest-numbered empty frame.
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = FRAME_IDX_W'(i);
			end
			if (empty[i]) begin
				empty_idx = FRAME_IDX_W'(i);
			end
		end
	end

	assign found     = |match;
	assign has_empty = |empty;

	// Oldest frame in use; a strict compare keeps the lowest index on ties.
	always_comb begin
		best   = rank_q[0];
		victim = '0;
		for (int i = 1; i < MAX_FRAMES; i++) begin
			if (in_use[i] && (rank_q[i] > best)) begin
				best   = rank_q[i];
				victim = FRAME_IDX_W'(i);
			end
		end
	end

	always_comb begin
		if (found) begin
			f_sel = hit_idx;
		end else if (has_empty) begin
			f_sel = empty_idx;
		end else begin
			f_sel = victim;
		end
	end

	assign f_was_valid = found || !has_empty;
	assign do_age      = !found || (cfg.policy_mode == POLICY_LRU);
	assign old_rank    = rank_q[f_sel];

	// Chosen frame becomes youngest; younger ones, or all on a fill, get one older.
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			rank_aged[i] = rank_q[i];
			if (in_use[i] && valid_q[i] && (FRAME_IDX_W'(i) != f_sel)
					&& (!f_was_valid || (rank_q[i] < old_rank))
					&& (rank_q[i] != RANK_W'(RANK_MAX))) begin
				rank_aged[i] = rank_q[i] + RANK_W'(1);
			end
		end
		rank_aged[f_sel] = '0;
	end

	assign faults_next = (faults_q != '1) ? faults_q + FAULT_W'(1) : faults_q;

	always_comb begin
		if (clear) begin
			rsp = '0;
		end else begin
			rsp.hit           = found;
			rsp.frame_index   = f_sel;
			rsp.evicted_valid = !found && !has_empty;
			rsp.evicted_page  = (!found && !has_empty) ? page_q[victim] : '0;
			rsp.fault_count   = found ? faults_q : faults_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			faults_q <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (commit) begin
			if (clear) begin
				valid_q  <= '0;
				faults_q <= '0;
				for (int i = 0; i < MAX_FRAMES; i++) begin
					rank_q[i] <= '0;
				end
			end else begin
				if (!found) begin
					valid_q[f_sel] <= 1'b1;
					faults_q       <= faults_next;
				end
				if (do_age) begin
					rank_q <= rank_aged;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && !clear && !found) begin
			page_q[f_sel] <= req_s1.page_number;
		end
	end

	`PRF_ASSERT(a_hit_never_evicts, !(found && !clear && rsp.evicted_valid))
	`PRF_ASSERT(a_evict_only_when_full, !(rsp.evicted_valid && has_empty))
	`PRF_ASSERT_NEXT(a_clear_empties, commit && clear, (valid_q == '0) && (faults_q == '0))
	`PRF_ASSERT_NEXT(a_fault_counts, commit && !clear && !found && (faults_q != '1), faults_q == $past(faults_q) + FAULT_W'(1))
	`PRF_ASSERT_NEXT(a_fill_marks_valid, commit && !clear && !found, valid_q != '0)
endmodule

// File: rtl/core/page_replacement_fifo_lru_core.sv
// ----------------------------------------------------------------------------
// Page replacement core, FIFO or LRU
// The request is registered in req_s1, then its response in rsp_s2 once that register
// is free or draining. Lookup, victim choice and aging are combinational.
// Throughput: one request per cycle while responses are taken.
// Reset empties all frames, zeroes ranks and fault count, config to 4 frames FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_replacement_fifo_lru_core (
	input  logic    clk,
	input  logic    arst_n,
	prf_req_if.sink req,
	prf_rsp_if.source rsp,
	prf_cfg_if.sink cfg
);
	import prf_pkg::*;

	cfg_t cfg_q;
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_d;
	rsp_t rsp_s2;
	logic valid_s2;
	logic advance;

	// A request moves into the response register when that register is free or draining.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	prf_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	prf_frame_table u_frame_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req_s1 (req_s1),
		.commit (advance),
		.rsp    (rsp_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (!valid_s2 || rsp.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.cmd         <= cmd_t'(req.cmd);
			req_s1.page_number <= req.page_number;
		end
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.hit           = rsp_s2.hit;
	assign rsp.frame_index   = rsp_s2.frame_index;
	assign rsp.evicted_valid = rsp_s2.evicted_valid;
	assign rsp.evicted_page  = rsp_s2.evicted_page;
	assign rsp.fault_count   = rsp_s2.fault_count;
endmodule
